>>> rtl/atan2au_pkg.sv
// Package for the atan2 angle unit: stage control struct, polynomial
// coefficients and the rounded Q1.15 multiply. No dependencies.
package atan2au_pkg;

	typedef struct packed {
		logic valid;
		logic last;
		logic undef;
		logic y_neg;
		logic x_neg;
		logic swap;
	} ctl_t;

	localparam int RatioFrac = 15;
	localparam int QuoWidth  = RatioFrac + 1;
	localparam int PolyWidth = 18;
	localparam int FoldWidth = 19;

	localparam logic signed [PolyWidth-1:0] COEF0 = 18'sd32764;
	localparam logic signed [PolyWidth-1:0] COEF1 = -18'sd10823;
	localparam logic signed [PolyWidth-1:0] COEF2 = 18'sd5903;
	localparam logic signed [PolyWidth-1:0] COEF3 = -18'sd2790;
	localparam logic signed [PolyWidth-1:0] COEF4 = 18'sd683;

	localparam logic signed [FoldWidth-1:0] PI_HALF_Q15 = 19'sd51472;
	localparam logic signed [FoldWidth-1:0] PI_Q15      = 19'sd102944;

	// floor((a*b + 2^14) / 2^15)
	function automatic logic signed [PolyWidth-1:0] mul_q15(
		input logic signed [PolyWidth-1:0] a,
		input logic signed [PolyWidth-1:0] b
	);
		logic signed [2*PolyWidth-1:0] prod;
		logic signed [2*PolyWidth-1:0] rnd;
		prod = a * b;
		rnd  = (prod + (36'sd1 <<< (RatioFrac - 1))) >>> RatioFrac;
		return rnd[PolyWidth-1:0];
	endfunction

endpackage

>>> rtl/atan2au_div.sv
// Range reduction and pipelined restoring divider: t = floor(lo * 2^15 / hi).
// Two quotient bits per divider stage, nine stages in all. Uses atan2au_pkg.
module atan2au_div #(
	parameter int W = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               en,
	input  atan2au_pkg::ctl_t                  ctl_in,
	input  logic [W-1:0]                       x,
	input  logic [W-1:0]                       y,
	output atan2au_pkg::ctl_t                  ctl_out,
	output logic [atan2au_pkg::QuoWidth-1:0]   t
);
	localparam int QW = atan2au_pkg::QuoWidth;
	localparam int NS = QW / 2;

	logic [W-1:0] ax, ay;
	atan2au_pkg::ctl_t ctl_c;

	atan2au_pkg::ctl_t ctl_s [NS+1];
	logic [W:0]        rem_s [NS+1];
	logic [W-1:0]      hi_s  [NS+1];
	logic [QW-1:0]     quo_s [NS+1];

	always_comb begin
		ax = x[W-1] ? (~x + 1'b1) : x;
		ay = y[W-1] ? (~y + 1'b1) : y;
		ctl_c = ctl_in;
		ctl_c.undef = (ax == '0) && (ay == '0);
		ctl_c.y_neg = y[W-1];
		ctl_c.x_neg = x[W-1];
		ctl_c.swap  = ay > ax;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s[0] <= '0;
		end else if (en) begin
			ctl_s[0] <= ctl_c;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= {1'b0, (ay > ax) ? ax : ay};
			hi_s[0]  <= (ay > ax) ? ay : ax;
			quo_s[0] <= '0;
		end
	end

	for (genvar j = 0; j < NS; j++) begin : g_stage
		logic [W:0]    r;
		logic [QW-1:0] q;

		always_comb begin
			r = rem_s[j];
			q = quo_s[j];
			for (int i = 0; i < 2; i++) begin
				if ((2 * j + i) != 0) begin
					r = {r[W-1:0], 1'b0};
				end
				if (r >= {1'b0, hi_s[j]}) begin
					r = r - {1'b0, hi_s[j]};
					q = {q[QW-2:0], 1'b1};
				end else begin
					q = {q[QW-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[j+1] <= '0;
			end else if (en) begin
				ctl_s[j+1] <= ctl_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j+1] <= r;
				hi_s[j+1]  <= hi_s[j];
				quo_s[j+1] <= q;
			end
		end
	end

	assign ctl_out = ctl_s[NS];
	assign t       = quo_s[NS];

endmodule

>>> rtl/atan2au_poly.sv
// Odd degree-9 Horner polynomial in Q1.15, one multiply per stage, six stages.
// Uses atan2au_pkg.
module atan2au_poly (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      en,
	input  atan2au_pkg::ctl_t                         ctl_in,
	input  logic [atan2au_pkg::QuoWidth-1:0]          t,
	output atan2au_pkg::ctl_t                         ctl_out,
	output logic signed [atan2au_pkg::PolyWidth-1:0]  p
);
	localparam int PW = atan2au_pkg::PolyWidth;
	localparam int QW = atan2au_pkg::QuoWidth;

	atan2au_pkg::ctl_t ctl_s [6];
	logic signed [PW-1:0] t_s   [6];
	logic signed [PW-1:0] t2_s  [6];
	logic signed [PW-1:0] acc_s [6];

	logic signed [PW-1:0] t_ext;
	assign t_ext = {{(PW-QW){1'b0}}, t};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 6; k++) begin
				ctl_s[k] <= '0;
			end
		end else if (en) begin
			ctl_s[0] <= ctl_in;
			for (int k = 1; k < 6; k++) begin
				ctl_s[k] <= ctl_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s[0]   <= t_ext;
			t2_s[0]  <= atan2au_pkg::mul_q15(t_ext, t_ext);
			acc_s[0] <= atan2au_pkg::COEF4;
			t_s[1]   <= t_s[0];
			t2_s[1]  <= t2_s[0];
			acc_s[1] <= atan2au_pkg::COEF3 + atan2au_pkg::mul_q15(t2_s[0], acc_s[0]);
			t_s[2]   <= t_s[1];
			t2_s[2]  <= t2_s[1];
			acc_s[2] <= atan2au_pkg::COEF2 + atan2au_pkg::mul_q15(t2_s[1], acc_s[1]);
			t_s[3]   <= t_s[2];
			t2_s[3]  <= t2_s[2];
			acc_s[3] <= atan2au_pkg::COEF1 + atan2au_pkg::mul_q15(t2_s[2], acc_s[2]);
			t_s[4]   <= t_s[3];
			t2_s[4]  <= t2_s[3];
			acc_s[4] <= atan2au_pkg::COEF0 + atan2au_pkg::mul_q15(t2_s[3], acc_s[3]);
			t_s[5]   <= t_s[4];
			t2_s[5]  <= t2_s[4];
			acc_s[5] <= atan2au_pkg::mul_q15(t_s[4], acc_s[4]);
		end
	end

	assign ctl_out = ctl_s[5];
	assign p       = acc_s[5];

endmodule

>>> rtl/atan2au_fold.sv
// Octant and quadrant folding, scaling to the output format and the output
// register. Uses atan2au_pkg.
module atan2au_fold #(
	parameter int AFB = 13
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      en,
	input  atan2au_pkg::ctl_t                         ctl_in,
	input  logic signed [atan2au_pkg::PolyWidth-1:0]  p,
	output atan2au_pkg::ctl_t                         ctl_out,
	output logic [AFB+2:0]                            angle
);
	localparam int AW = AFB + 3;
	localparam int FW = atan2au_pkg::FoldWidth;
	localparam int MW = AW + FW;
	localparam int SH = atan2au_pkg::RatioFrac - AFB;

	logic signed [FW-1:0] m1, m2;
	logic [MW-1:0] mw, msh;
	logic [AW-1:0] mt, res;
	atan2au_pkg::ctl_t ctl_q;
	logic [AW-1:0] angle_q;

	always_comb begin
		m1 = ctl_in.swap ? (atan2au_pkg::PI_HALF_Q15 - FW'(p)) : FW'(p);
		m2 = ctl_in.x_neg ? (atan2au_pkg::PI_Q15 - m1) : m1;
		if (m2 < 0) begin
			m2 = '0;
		end
		mw = {{AW{1'b0}}, m2};
	end

	if (SH > 0) begin : g_rshift
		assign msh = (mw + (MW'(1) << (SH - 1))) >> SH;
	end else begin : g_lshift
		assign msh = mw << (-SH);
	end

	always_comb begin
		mt  = msh[AW-1:0];
		res = ctl_in.y_neg ? (~mt + 1'b1) : mt;
		if (ctl_in.undef) begin
			res = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (en) begin
			ctl_q <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			angle_q <= res;
		end
	end

	assign ctl_out = ctl_q;
	assign angle   = angle_q;

endmodule

>>> rtl/atan2_angle_unit_top.sv
// Four-quadrant arc tangent unit, top level.
// Depends on atan2au_pkg, atan2au_div, atan2au_poly and atan2au_fold.
//
// Usage:
//   Input channel: in_valid / in_stall carry one word of x_denominator,
//   y_numerator and last_in. A word is taken on a rising edge with in_valid
//   high and in_stall low.
//   Output channel: out_valid / out_stall carry angle (signed Q3.AFB radians),
//   undefined_flag (x = y = 0, angle then zero) and last_out.
//   Pipeline: one range reduction stage, eight divider stages of two
//   quotient bits, six multiplier stages of the polynomial and the
//   output fold register.
//   Throughput: one word per cycle while the output is not stalled.
//   When the receiver stalls a valid result, the whole pipeline holds and
//   in_stall rises in the same cycle; nothing is dropped or repeated.
//   Reset (arst_n low) clears all valid bits at once; data registers are
//   left as they are.
module atan2_angle_unit_top #(
	parameter int IN_WIDTH        = 16,
	parameter int ANGLE_FRAC_BITS = 13
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [IN_WIDTH-1:0]          x_denominator,
	input  logic [IN_WIDTH-1:0]          y_numerator,
	input  logic                         last_in,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [ANGLE_FRAC_BITS+2:0]   angle,
	output logic                         undefined_flag,
	output logic                         last_out
);
	atan2au_pkg::ctl_t ctl_in, ctl_div, ctl_poly, ctl_out;
	logic [atan2au_pkg::QuoWidth-1:0] t;
	logic signed [atan2au_pkg::PolyWidth-1:0] p;
	logic en;

	assign en       = !(ctl_out.valid && out_stall);
	assign in_stall = !en;

	always_comb begin
		ctl_in       = '0;
		ctl_in.valid = in_valid;
		ctl_in.last  = last_in;
	end

	atan2au_div #(.W(IN_WIDTH)) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.ctl_in  (ctl_in),
		.x       (x_denominator),
		.y       (y_numerator),
		.ctl_out (ctl_div),
		.t       (t)
	);

	atan2au_poly u_poly (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.ctl_in  (ctl_div),
		.t       (t),
		.ctl_out (ctl_poly),
		.p       (p)
	);

	atan2au_fold #(.AFB(ANGLE_FRAC_BITS)) u_fold (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.ctl_in  (ctl_poly),
		.p       (p),
		.ctl_out (ctl_out),
		.angle   (angle)
	);

	assign out_valid      = ctl_out.valid;
	assign undefined_flag = ctl_out.undef;
	assign last_out       = ctl_out.last;

`ifndef ASSERT_OFF
	a_undef_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && undefined_flag |-> angle == '0)
		else $error("undefined result with nonzero angle");

	a_stall_link: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("input stall not tied to held output");

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> out_valid)
		else $error("held result lost");
`endif

endmodule
